### src/prdd_pkg.sv
// shared types and constants of the progress rate drift detector
`timescale 1ns / 1ps
`default_nettype none
package prdd_pkg;

  localparam int STAMP_W     = 48;
  localparam int HALF_W      = 24;
  localparam int THR_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 8'd1;

  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd13107;
  localparam logic [STAMP_W-1:0] SPEED_MAX       = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_AVG,
    ST_FLAG,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic latch_first;
    logic mul_lo;
    logic mul_hi;
    logic mul_sum;
    logic div_start;
    logic speed_sat;
    logic take_div;
    logic avg_update;
    logic flag_update;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic stamp_pos;
    logic started;
    logic stamp_ahead;
    logic elapsed_zero;
    logic avg_valid;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### src/prdd_in_if.sv
// input item channel
`timescale 1ns / 1ps
`default_nettype none
interface prdd_in_if;
  import prdd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [STAMP_W-1:0] progress_stamp;
  logic [STAMP_W-1:0]        wall_time_us;
  modport source(output valid, progress_stamp, wall_time_us, input ready);
  modport sink(input valid, progress_stamp, wall_time_us, output ready);
endinterface
`default_nettype wire

### src/prdd_out_if.sv
// result item channel
`timescale 1ns / 1ps
`default_nettype none
interface prdd_out_if;
  import prdd_pkg::*;
  logic               valid;
  logic               ready;
  logic               drift_flag;
  logic [STAMP_W-1:0] average_speed;
  modport source(output valid, drift_flag, average_speed, input ready);
  modport sink(input valid, drift_flag, average_speed, output ready);
endinterface
`default_nettype wire

### src/prdd_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface prdd_cfg_if;
  import prdd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/progress_rate_drift_detector.sv
// progress rate drift detector top level
// one item at a time; an item that changes nothing or only latches goes on to ST_DONE
// a zero elapsed time goes to ST_AVG; a measured speed first passes ST_MUL_LO, ST_MUL_HI,
// ST_MUL_SUM, ST_DIV_START, ST_DIV_WAIT (one quotient bit a cycle); no ST_FLAG when it seeds
// the result register lets the next item in while a result waits to be taken
// synchronous reset clears the running state, reference to zero, threshold to 13107
`timescale 1ns / 1ps
`default_nettype none
module progress_rate_drift_detector #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input wire logic clk,
  input wire logic rst,
  prdd_in_if.sink      item_in,
  prdd_out_if.source   result_out,
  prdd_cfg_if.sink     cfg
);
  import prdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  prdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  prdd_datapath #(.TICKS_PER_SECOND(TICKS_PER_SECOND)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_stamp    (item_in.progress_stamp),
    .in_time     (item_in.wall_time_us),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_flag    (result_out.drift_flag),
    .out_average (result_out.average_speed)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_in.valid && item_in.ready) |=> !item_in.ready)
    else $error("block took an item while still working");

  a_div_consumed: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> cmd.take_div)
    else $error("divider result not taken");

  a_reference_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && (cfg.index == REG_REFERENCE)) |=> (!status.started && !status.avg_valid))
    else $error("reference write did not clear running state");
`endif
endmodule
`default_nettype wire

### src/prdd_div.sv
// restoring divider, one quotient bit a cycle, quotient saturated to 48 bits
`timescale 1ns / 1ps
`default_nettype none
module prdd_div #(
  parameter int DVD_W = 68
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [DVD_W-1:0]            dividend,
  input  wire logic [prdd_pkg::STAMP_W-1:0] divisor,
  output logic                             done,
  output logic [prdd_pkg::STAMP_W-1:0]     quotient
);
  import prdd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   dvd;
  logic [STAMP_W-1:0] dsr;
  logic [STAMP_W-1:0] rem;
  logic [STAMP_W-1:0] q;
  logic               ovf;
  logic [STAMP_W:0]   trial;
  logic               fits;

  assign trial = {rem, dvd[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
    end else if (active) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= fits ? STAMP_W'(trial - {1'b0, dsr}) : trial[STAMP_W-1:0];
      q   <= {q[STAMP_W-2:0], fits};
      ovf <= ovf | q[STAMP_W-1];
    end
  end

  assign quotient = ovf ? SPEED_MAX : q;
endmodule
`default_nettype wire

### src/prdd_datapath.sv
// datapath: running state, speed product, divider, average, flag and result register
`timescale 1ns / 1ps
`default_nettype none
module prdd_datapath #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire prdd_pkg::dp_cmd_t                   cmd,
  output prdd_pkg::dp_status_t                     status,
  input  wire logic signed [prdd_pkg::STAMP_W-1:0] in_stamp,
  input  wire logic [prdd_pkg::STAMP_W-1:0]        in_time,
  input  wire logic                                cfg_write,
  input  wire logic [prdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [prdd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_flag,
  output logic [prdd_pkg::STAMP_W-1:0]             out_average
);
  import prdd_pkg::*;

  localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W = STAMP_W + TICK_W;
  localparam int PART_W = HALF_W + TICK_W;
  localparam logic [TICK_W-1:0] TICKS = TICK_W'(TICKS_PER_SECOND);

  logic signed [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0]        now;
  logic signed [STAMP_W-1:0] last_stamp;
  logic [STAMP_W-1:0]        last_wall_time;
  logic                      started;
  logic                      average_valid;
  logic [STAMP_W-1:0]        running_average;
  logic                      flag_held;
  logic [STAMP_W-1:0]        reference_speed;
  logic [THR_W-1:0]          drift_threshold;

  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [STAMP_W-1:0] speed;

  logic [STAMP_W-1:0]   delta;
  logic [STAMP_W-1:0]   elapsed;
  logic                 div_done;
  logic [STAMP_W-1:0]   div_q;
  logic [STAMP_W+1:0]   avg_sum;
  logic [STAMP_W-1:0]   avg_new;
  logic [STAMP_W-1:0]   diff;
  logic [STAMP_W+THR_W-1:0] scaled;
  logic                 cfg_ref;

  assign delta   = STAMP_W'(stamp - last_stamp);
  assign elapsed = now - last_wall_time;
  assign avg_sum = (STAMP_W+2)'(running_average) * (STAMP_W+2)'(3)
                 + (STAMP_W+2)'(speed);
  assign avg_new = avg_sum[STAMP_W+1:2];
  assign diff    = (running_average > reference_speed) ?
                   running_average - reference_speed :
                   reference_speed - running_average;
  assign scaled  = (STAMP_W+THR_W)'(running_average) * (STAMP_W+THR_W)'(drift_threshold);
  assign cfg_ref = cfg_write && (cfg_index == REG_REFERENCE);

  prdd_div #(.DVD_W(PROD_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      stamp <= in_stamp;
      now   <= in_time;
    end
    if (cmd.mul_lo) begin
      part <= PART_W'(delta[HALF_W-1:0] * TICKS);
    end
    if (cmd.mul_hi) begin
      prod <= PROD_W'(part);
      part <= PART_W'(delta[STAMP_W-1:HALF_W] * TICKS);
    end
    if (cmd.mul_sum) begin
      prod <= prod + (PROD_W'(part) << HALF_W);
    end
    if (cmd.speed_sat) begin
      speed <= SPEED_MAX;
    end else if (cmd.take_div) begin
      speed <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      average_valid   <= 1'b0;
      running_average <= '0;
      flag_held       <= 1'b0;
      last_stamp      <= '0;
      last_wall_time  <= '0;
      reference_speed <= '0;
      drift_threshold <= THRESHOLD_RESET;
    end else begin
      if (cmd.latch_first || cmd.avg_update) begin
        started        <= 1'b1;
        last_stamp     <= stamp;
        last_wall_time <= now;
      end
      if (cmd.avg_update) begin
        if (average_valid) begin
          running_average <= avg_new;
        end else if (speed != '0) begin
          running_average <= speed;
          average_valid   <= 1'b1;
        end
      end
      if (cmd.flag_update) begin
        flag_held <= scaled < {diff, {THR_W{1'b0}}};
      end
      if (cfg_ref) begin
        reference_speed <= cfg_data[STAMP_W-1:0];
        started         <= 1'b0;
        average_valid   <= 1'b0;
        running_average <= '0;
        flag_held       <= 1'b0;
      end
      if (cfg_write && (cfg_index == REG_THRESHOLD)) begin
        drift_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flag    <= flag_held;
      out_average <= running_average;
    end
  end

  always_comb begin
    status.stamp_pos    = !stamp[STAMP_W-1] && (stamp != '0);
    status.started      = started;
    status.stamp_ahead  = stamp > last_stamp;
    status.elapsed_zero = elapsed == '0;
    status.avg_valid    = average_valid;
    status.div_done     = div_done;
    status.out_free     = !out_valid || out_ready;
  end
endmodule
`default_nettype wire

### src/prdd_ctrl.sv
// controller state machine sequencing one item through the datapath
`timescale 1ns / 1ps
`default_nettype none
module prdd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire prdd_pkg::dp_status_t status,
  output prdd_pkg::dp_cmd_t         cmd
);
  import prdd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.stamp_pos || !status.started) begin
          state_next = ST_DONE;
        end else if (!status.stamp_ahead) begin
          state_next = ST_DONE;
        end else if (status.elapsed_zero) begin
          state_next = ST_AVG;
        end else begin
          state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_MUL_SUM;
      ST_MUL_SUM:   state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) state_next = ST_AVG;
      end
      ST_AVG:  state_next = status.avg_valid ? ST_FLAG : ST_DONE;
      ST_FLAG: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_CHECK: begin
        cmd.latch_first = status.stamp_pos && !status.started;
        cmd.speed_sat   = status.stamp_pos && status.started && status.stamp_ahead
                          && status.elapsed_zero;
      end
      ST_MUL_LO:    cmd.mul_lo = 1'b1;
      ST_MUL_HI:    cmd.mul_hi = 1'b1;
      ST_MUL_SUM:   cmd.mul_sum = 1'b1;
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT:  cmd.take_div = status.div_done;
      ST_AVG:       cmd.avg_update = 1'b1;
      ST_FLAG:      cmd.flag_update = 1'b1;
      ST_DONE:      cmd.out_load = status.out_free;
      default:      cmd = '0;
    endcase
  end
endmodule
`default_nettype wire
